[src/rdsm_pkg.sv]
package rdsm_pkg;

	localparam int unsigned MAX_ELEMENTS_DEF = 16;
	localparam int unsigned SYM_W = 8;

	localparam logic [SYM_W-1:0] SYM_ANY  = 8'h2E;
	localparam logic [SYM_W-1:0] SYM_STAR = 8'h2A;

	typedef enum logic [1:0] {
		CMD_PATTERN = 2'd0,
		CMD_TEXT    = 2'd1,
		CMD_END     = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	// broadcast to every cell
	typedef struct packed {
		logic             text;
		logic             append;
		logic             star;
		logic             rearm;
		logic             clear;
		logic [SYM_W-1:0] symbol;
	} cell_ctrl_t;

	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} result_t;

endpackage

[src/rdsm_cmd_if.sv]
interface rdsm_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   cmd;
	logic [rdsm_pkg::SYM_W-1:0]   symbol;

	modport source (output valid, output cmd, output symbol, input ready);
	modport sink   (input valid, input cmd, input symbol, output ready);
endinterface

[src/rdsm_res_if.sv]
interface rdsm_res_if;
	logic valid;
	logic ready;
	logic matched;
	logic pattern_overflow;

	modport source (output valid, output matched, output pattern_overflow, input ready);
	modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

[src/rdsm_cell.sv]
module rdsm_cell #(
	parameter bit HOME = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rdsm_pkg::cell_ctrl_t ctl,
	input  logic                 valid_prev,
	input  logic                 valid_next,
	input  logic                 close_in,
	input  logic                 move_in,
	output logic                 valid,
	output logic                 close_out,
	output logic                 move_out,
	output logic                 last_unstarred,
	output logic                 hit_end
);

	logic                       valid_q;
	logic                       starred_q;
	logic                       active_q;
	logic [rdsm_pkg::SYM_W-1:0] sym_q;
	logic                       closed;
	logic                       hit;
	logic                       is_last;
	logic                       append_here;
	logic                       active_d;

	assign closed      = active_q | close_in;
	assign hit         = valid_q & closed &
	                     ((sym_q == rdsm_pkg::SYM_ANY) || (sym_q == ctl.symbol));
	assign is_last     = valid_q & ~valid_next;
	assign append_here = valid_prev & ~valid_q;

	assign valid          = valid_q;
	assign close_out      = closed & starred_q & valid_q;
	assign move_out       = hit & ~starred_q;
	assign last_unstarred = is_last & ~starred_q;
	assign hit_end        = closed & valid_prev & ~valid_q;
	assign active_d       = (hit & starred_q) | move_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			starred_q <= 1'b0;
			active_q  <= HOME;
		end else begin
			if (ctl.clear) begin
				valid_q   <= 1'b0;
				starred_q <= 1'b0;
			end else if (ctl.append && append_here) begin
				valid_q   <= 1'b1;
				starred_q <= 1'b0;
			end else if (ctl.star && is_last) begin
				starred_q <= 1'b1;
			end
			if (ctl.rearm) begin
				active_q <= HOME;
			end else if (ctl.text) begin
				active_q <= active_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.append && append_here) begin
			sym_q <= ctl.symbol;
		end
	end

endmodule

[src/rdsm_res_queue.sv]
module rdsm_res_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rdsm_pkg::result_t push_data,
	output logic              space,
	rdsm_res_if.source        rsp
);

	logic [1:0]        cnt_q;
	rdsm_pkg::result_t ent0_q;
	rdsm_pkg::result_t ent1_q;
	logic              pop;

	assign space                = (cnt_q != 2'd2);
	assign rsp.valid            = (cnt_q != 2'd0);
	assign rsp.matched          = ent0_q.matched;
	assign rsp.pattern_overflow = ent0_q.pattern_overflow;
	assign pop                  = rsp.valid & rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b11: begin
				if (cnt_q == 2'd1) begin
					ent0_q <= push_data;
				end else begin
					ent0_q <= ent1_q;
					ent1_q <= push_data;
				end
			end
			2'b10: begin
				if (cnt_q == 2'd0) begin
					ent0_q <= push_data;
				end else begin
					ent1_q <= push_data;
				end
			end
			2'b01: begin
				ent0_q <= ent1_q;
			end
			default: begin
			end
		endcase
	end

endmodule

[src/regex_dot_star_matcher_unit.sv]
// Each result enters the registered result queue on its end-of-text transfer.
// Throughput: one command per cycle while req is ready; the active-set update ripples
// through the row of cells in the same cycle, so that chain sets the clock path.
// A two-entry result queue keeps req ready unless both entries are pending.
// Reset (arst_n low): pattern empty, overflow clear, position zero armed, queue empty.
module regex_dot_star_matcher_unit #(
	parameter int unsigned MAX_ELEMENTS = rdsm_pkg::MAX_ELEMENTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rdsm_cmd_if.sink   req,
	rdsm_res_if.source rsp
);

	rdsm_pkg::cell_ctrl_t ctl;
	rdsm_pkg::cmd_t       cmd;
	rdsm_pkg::result_t    res;

	logic [MAX_ELEMENTS:0]   valid_chain;
	logic [MAX_ELEMENTS:0]   close_chain;
	logic [MAX_ELEMENTS:0]   move_chain;
	logic [MAX_ELEMENTS-1:0] valid_vec;
	logic [MAX_ELEMENTS-1:0] last_unstarred;
	logic [MAX_ELEMENTS-1:0] hit_end;
	logic [MAX_ELEMENTS:0]   valid_right;

	logic ovf_q;
	logic term_q;
	logic fire;
	logic space;
	logic load_ok;
	logic full;
	logic any_star;
	logic match;

	assign cmd      = rdsm_pkg::cmd_t'(req.cmd);
	assign req.ready = space;
	assign fire     = req.valid & space;
	assign full     = valid_vec[MAX_ELEMENTS-1];
	assign any_star = |last_unstarred;
	assign load_ok  = fire & (cmd == rdsm_pkg::CMD_PATTERN) & ~ovf_q;

	always_comb begin
		ctl.symbol = req.symbol;
		ctl.text   = fire & (cmd == rdsm_pkg::CMD_TEXT);
		ctl.star   = load_ok & (req.symbol == rdsm_pkg::SYM_STAR) & any_star;
		ctl.append = load_ok & ~ctl.star & ~full;
		ctl.clear  = fire & (cmd == rdsm_pkg::CMD_CLEAR);
		ctl.rearm  = fire & ((cmd == rdsm_pkg::CMD_END) || (cmd == rdsm_pkg::CMD_CLEAR));
	end

	assign valid_chain[0] = 1'b1;
	assign close_chain[0] = 1'b0;
	assign move_chain[0]  = 1'b0;
	assign valid_right[MAX_ELEMENTS] = 1'b0;

	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
		assign valid_right[i] = valid_vec[i];
		assign valid_chain[i+1] = valid_vec[i];

		rdsm_cell #(
			.HOME (i == 0)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctl            (ctl),
			.valid_prev     (valid_chain[i]),
			.valid_next     (valid_right[i+1]),
			.close_in       (close_chain[i]),
			.move_in        (move_chain[i]),
			.valid          (valid_vec[i]),
			.close_out      (close_chain[i+1]),
			.move_out       (move_chain[i+1]),
			.last_unstarred (last_unstarred[i]),
			.hit_end        (hit_end[i])
		);
	end

	// terminal position, reached only when every element is loaded
	assign match = (|hit_end) | ((term_q | close_chain[MAX_ELEMENTS]) & full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q  <= 1'b0;
			term_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				ovf_q <= 1'b0;
			end else if (load_ok && !ctl.star && full) begin
				ovf_q <= 1'b1;
			end
			if (ctl.rearm) begin
				term_q <= 1'b0;
			end else if (ctl.text) begin
				term_q <= move_chain[MAX_ELEMENTS];
			end
		end
	end

	assign res.matched          = match & ~ovf_q;
	assign res.pattern_overflow = ovf_q;

	rdsm_res_queue u_res_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire & (cmd == rdsm_pkg::CMD_END)),
		.push_data (res),
		.space     (space),
		.rsp       (rsp)
	);

endmodule

[sim/regex_dot_star_matcher_unit_test.sv]
`timescale 1ns / 100ps

module regex_dot_star_matcher_unit_test;

	localparam int MAXE = rdsm_pkg::MAX_ELEMENTS_DEF;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		rdsm_pkg::cmd_t op;
		logic [7:0]     sym;
	} cmd_item_t;

	logic clk = 1'b0;
	logic arst_n;

	rdsm_cmd_if cmd_ch ();
	rdsm_res_if res_ch ();

	regex_dot_star_matcher_unit dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (cmd_ch),
		.rsp   (res_ch)
	);

	always #5 clk = ~clk;

	cmd_item_t         cmd_q [$];
	rdsm_pkg::result_t awaited_results [$];
	int                mismatch_count = 0;
	int                queued_n = 0;
	int                cycle_count = 0;
	int                send_idle_pct = 0;
	int                recv_stall_pct = 0;
	int                hold_req = 0;
	logic              cmd_fired = 1'b0;

	// matcher state as the block should hold it
	logic [7:0]  patt_sym [MAXE];
	bit          patt_star [MAXE];
	int unsigned patt_len = 0;
	bit [MAXE:0] live_pos = (MAXE+1)'(1);
	bit          patt_ovf = 1'b0;

	// stimulus-side view of the loaded pattern
	logic [7:0] gen_sym [MAXE+4];
	bit         gen_star [MAXE+4];
	int         gen_len = -1;

	task automatic settle_live();
		for (int i = 0; i < MAXE && i < patt_len; i++) begin
			if (live_pos[i] && patt_star[i])
				live_pos[i+1] = 1'b1;
		end
	endtask

	task automatic absorb_transfer(rdsm_pkg::cmd_t op, logic [7:0] b);
		bit [MAXE:0]       nxt;
		rdsm_pkg::result_t v;
		case (op)
			rdsm_pkg::CMD_PATTERN: begin
				if (!patt_ovf) begin
					if (b == rdsm_pkg::SYM_STAR && patt_len > 0 &&
						!patt_star[patt_len-1]) begin
						patt_star[patt_len-1] = 1'b1;
					end else if (patt_len >= MAXE) begin
						patt_ovf = 1'b1;
					end else begin
						patt_sym[patt_len] = b;
						patt_star[patt_len] = 1'b0;
						patt_len++;
					end
				end
			end
			rdsm_pkg::CMD_TEXT: begin
				settle_live();
				nxt = '0;
				for (int i = 0; i < MAXE && i < patt_len; i++) begin
					if (live_pos[i] &&
						(patt_sym[i] == rdsm_pkg::SYM_ANY || patt_sym[i] == b)) begin
						if (patt_star[i])
							nxt[i] = 1'b1;
						else
							nxt[i+1] = 1'b1;
					end
				end
				live_pos = nxt;
			end
			rdsm_pkg::CMD_END: begin
				settle_live();
				v.matched = live_pos[patt_len] && !patt_ovf;
				v.pattern_overflow = patt_ovf;
				awaited_results.push_back(v);
				live_pos = (MAXE+1)'(1);
			end
			default: begin
				for (int i = 0; i < MAXE; i++)
					patt_star[i] = 1'b0;
				patt_len = 0;
				patt_ovf = 1'b0;
				live_pos = (MAXE+1)'(1);
			end
		endcase
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL regex_dot_star_matcher_unit");
			$finish;
		end
	end

	// driver
	always @(negedge clk) begin : drive
		cmd_item_t nxt;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else if (!cmd_ch.valid || cmd_fired) begin
			if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = cmd_q.pop_front();
				cmd_ch.valid <= 1'b1;
				cmd_ch.cmd <= nxt.op;
				cmd_ch.symbol <= nxt.sym;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver, with a long hold-off on request
	always @(negedge clk) begin : receive
		static int hold_left = 0;
		static int hold_ack = 0;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			res_ch.ready <= 1'b0;
			hold_left--;
		end else if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = HOLD_CYCLES;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin : watch
		rdsm_pkg::result_t want;
		cmd_fired <= arst_n && cmd_ch.valid && cmd_ch.ready;
		if (arst_n && cmd_ch.valid && cmd_ch.ready)
			absorb_transfer(rdsm_pkg::cmd_t'(cmd_ch.cmd), cmd_ch.symbol);
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: result with none pending: matched=%0b overflow=%0b",
					$time, res_ch.matched, res_ch.pattern_overflow);
				mismatch_count++;
			end else begin
				want = awaited_results.pop_front();
				if (res_ch.matched !== want.matched) begin
					$display("%0t: matched expected %0b actual %0b",
						$time, want.matched, res_ch.matched);
					mismatch_count++;
				end
				if (res_ch.pattern_overflow !== want.pattern_overflow) begin
					$display("%0t: pattern_overflow expected %0b actual %0b",
						$time, want.pattern_overflow, res_ch.pattern_overflow);
					mismatch_count++;
				end
			end
		end
	end

	task automatic tick();
		@(posedge clk);
		#1;
	endtask

	task automatic wait_drained();
		while (cmd_q.size() != 0 || cmd_ch.valid || awaited_results.size() != 0)
			tick();
	endtask

	task automatic queue_item(rdsm_pkg::cmd_t op, logic [7:0] b);
		cmd_item_t it;
		it.op = op;
		it.sym = b;
		cmd_q.push_back(it);
		queued_n++;
	endtask

	function automatic logic [7:0] pick_pattern_symbol();
		int r;
		r = $urandom_range(99);
		if (r < 30)
			return "a";
		else if (r < 55)
			return "b";
		else if (r < 70)
			return rdsm_pkg::SYM_ANY;
		else if (r < 80)
			return "c";
		else
			return 8'($urandom_range(255));
	endfunction

	task automatic queue_sequence();
		int         n;
		int         r;
		int         reps;
		int         idx;
		logic [7:0] txt [$];
		if (gen_len < 0 || $urandom_range(99) < 80) begin
			queue_item(rdsm_pkg::CMD_CLEAR, 8'($urandom_range(255)));
			r = $urandom_range(99);
			if (r < 6)
				n = $urandom_range(MAXE + 3, MAXE + 1);
			else if (r < 20)
				n = $urandom_range(MAXE, 9);
			else
				n = $urandom_range(8, 0);
			for (int k = 0; k < n; k++) begin
				gen_sym[k] = pick_pattern_symbol();
				// a star here would star the previous element instead
				if (gen_sym[k] == rdsm_pkg::SYM_STAR && k > 0 && !gen_star[k-1])
					gen_sym[k] = "a";
				gen_star[k] = ($urandom_range(2) == 0);
				queue_item(rdsm_pkg::CMD_PATTERN, gen_sym[k]);
				if (gen_star[k])
					queue_item(rdsm_pkg::CMD_PATTERN, rdsm_pkg::SYM_STAR);
			end
			gen_len = n;
		end
		for (int k = 0; k < gen_len; k++) begin
			reps = gen_star[k] ? $urandom_range(3, 0) : 1;
			for (int j = 0; j < reps; j++)
				txt.push_back(gen_sym[k] == rdsm_pkg::SYM_ANY ?
					8'($urandom_range(255)) : gen_sym[k]);
		end
		r = $urandom_range(99);
		if (r < 10 && txt.size() != 0) begin
			idx = $urandom_range(txt.size() - 1);
			txt[idx] = 8'($urandom_range(255));
		end else if (r < 17) begin
			txt.push_back(8'($urandom_range(255)));
		end else if (r < 25 && txt.size() != 0) begin
			txt.delete($urandom_range(txt.size() - 1));
		end
		foreach (txt[i]) begin
			if ($urandom_range(99) < 4)
				queue_item(rdsm_pkg::CMD_PATTERN, pick_pattern_symbol());
			queue_item(rdsm_pkg::CMD_TEXT, txt[i]);
		end
		queue_item(rdsm_pkg::CMD_END, 8'($urandom_range(255)));
	endtask

	task automatic queue_random_stretch(int budget);
		int start;
		int burst;
		start = queued_n;
		while (queued_n - start < budget) begin
			if ($urandom_range(99) < 8) begin
				burst = $urandom_range(3, 1);
				for (int i = 0; i < burst; i++)
					queue_item(rdsm_pkg::cmd_t'(2'($urandom_range(3))),
						8'($urandom_range(255)));
			end else begin
				queue_sequence();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		#2 arst_n = 1'b1;

		// empty pattern, literal and starred star, dot, pattern bytes during text
		queue_item(rdsm_pkg::CMD_END, 8'h00);
		queue_item(rdsm_pkg::CMD_TEXT, 8'hFF);
		queue_item(rdsm_pkg::CMD_END, 8'h00);
		queue_item(rdsm_pkg::CMD_PATTERN, rdsm_pkg::SYM_STAR);
		queue_item(rdsm_pkg::CMD_PATTERN, rdsm_pkg::SYM_STAR);
		queue_item(rdsm_pkg::CMD_PATTERN, rdsm_pkg::SYM_STAR);
		queue_item(rdsm_pkg::CMD_TEXT, rdsm_pkg::SYM_STAR);
		queue_item(rdsm_pkg::CMD_TEXT, rdsm_pkg::SYM_STAR);
		queue_item(rdsm_pkg::CMD_END, 8'h00);
		queue_item(rdsm_pkg::CMD_CLEAR, 8'h00);
		queue_item(rdsm_pkg::CMD_PATTERN, rdsm_pkg::SYM_ANY);
		queue_item(rdsm_pkg::CMD_TEXT, 8'h00);
		queue_item(rdsm_pkg::CMD_PATTERN, rdsm_pkg::SYM_STAR);
		queue_item(rdsm_pkg::CMD_END, 8'h00);
		queue_item(rdsm_pkg::CMD_CLEAR, 8'h00);
		queue_item(rdsm_pkg::CMD_PATTERN, 8'h00);
		queue_item(rdsm_pkg::CMD_PATTERN, 8'hFF);
		queue_item(rdsm_pkg::CMD_TEXT, 8'h00);
		queue_item(rdsm_pkg::CMD_TEXT, 8'hFF);
		queue_item(rdsm_pkg::CMD_END, 8'hFF);
		queue_item(rdsm_pkg::CMD_CLEAR, 8'hFF);
		queue_item(rdsm_pkg::CMD_END, 8'hAA);
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			queue_random_stretch(300);
			wait_drained();
		end

		// back-pressure: results pile up while commands keep coming
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < 20; i++) begin
			queue_item(rdsm_pkg::CMD_TEXT, 8'($urandom_range(255)));
			queue_item(rdsm_pkg::CMD_END, 8'($urandom_range(255)));
		end
		hold_req++;
		wait_drained();

		repeat (5) tick();
		if (mismatch_count == 0)
			$display("PASS regex_dot_star_matcher_unit");
		else
			$display("FAIL regex_dot_star_matcher_unit");
		$finish;
	end

endmodule

[filelist.f]
src/rdsm_pkg.sv
src/rdsm_cmd_if.sv
src/rdsm_res_if.sv
src/rdsm_cell.sv
src/rdsm_res_queue.sv
src/regex_dot_star_matcher_unit.sv
sim/regex_dot_star_matcher_unit_test.sv
